>>> hdl/bsae_pkg.sv
// ----------------------------------------------------------------------------
// Bech32 segwit address encoder package
// Shared types, constants and the polymod and alphabet functions.
// ----------------------------------------------------------------------------
package bsae_pkg;

  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;
  localparam int ChkLen     = 6;

  localparam logic [29:0] SeedReset    = 30'h2318043;
  localparam logic [29:0] Bech32Const  = 30'h0000001;
  localparam logic [29:0] Bech32mConst = 30'h2bc830a3;

  localparam logic CfgIdxVersion = 1'b0;
  localparam logic CfgIdxSeed    = 1'b1;

  localparam logic [7:0] Alphabet [0:31] = '{
    "q", "p", "z", "r", "y", "9", "x", "8",
    "g", "f", "2", "t", "v", "d", "w", "0",
    "s", "3", "j", "n", "5", "4", "k", "h",
    "c", "e", "6", "m", "u", "a", "7", "l"
  };

  typedef struct packed {
    logic [7:0]  program_byte;
    logic        final_byte;
    logic        first;
    logic [4:0]  version;
    logic [29:0] seed;
  } bsae_entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } bsae_q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_VER,
    BK_SYM,
    BK_PAD,
    BK_CRC,
    BK_OUT
  } bsae_back_state_t;

  function automatic logic [29:0] polymod_step(input logic [29:0] v);
    logic [4:0]  top;
    logic [29:0] r;
    top = v[29:25];
    r   = {v[24:0], 5'b00000};
    if (top[0]) r = r ^ 30'h3b6a57b2;
    if (top[1]) r = r ^ 30'h26508e6d;
    if (top[2]) r = r ^ 30'h1ea119fa;
    if (top[3]) r = r ^ 30'h3d4233dd;
    if (top[4]) r = r ^ 30'h2a1462b3;
    return r;
  endfunction

  function automatic logic [6:0] sym_char(input logic [4:0] s);
    logic [7:0] c;
    c = Alphabet[s];
    return c[6:0];
  endfunction

endpackage

>>> hdl/bech32_segwit_address_encoder.sv
// Each byte but an address's first passes the queue and then the output register;
// an address's first byte passes the queue, a seed load, then the version symbol.
// At most one character per cycle leaves while out_stall is low; a byte gives one
// or two symbols; an address's first byte adds a seed load and the version symbol;
// the final byte adds any padding symbol, polymod steps and six checksum characters.
// Reset is synchronous and active low; it restores the default seed and version.
// ----------------------------------------------------------------------------
// Bech32 segwit address encoder
// Turns witness program bytes into bech32 or bech32m data and checksum
// characters.
// ----------------------------------------------------------------------------
module bech32_segwit_address_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_program_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_address_char,
  output logic        out_last_char,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [29:0] cfg_data
);
  import bsae_pkg::*;

  bsae_q_status_t q_status;
  bsae_entry_t    q_entry;
  bsae_entry_t    q_head;
  logic           q_push;
  logic           q_pop;

  bsae_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_program_byte (in_program_byte),
    .in_final_byte   (in_final_byte),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_status        (q_status),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  bsae_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  bsae_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .head_valid       (q_status.not_empty),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_address_char (out_address_char),
    .out_last_char    (out_last_char)
  );

endmodule

>>> hdl/bsae_front.sv
// ----------------------------------------------------------------------------
// Bech32 encoder front end
// Holds the configuration registers, accepts program bytes and tags each one
// with its address position and the configuration in force at acceptance.
// ----------------------------------------------------------------------------
module bsae_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_program_byte,
  input  logic                   in_final_byte,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [29:0]            cfg_data,
  input  bsae_pkg::bsae_q_status_t q_status,
  output logic                   q_push,
  output bsae_pkg::bsae_entry_t  q_entry
);
  import bsae_pkg::*;

  logic [4:0]  version_r;
  logic [29:0] seed_r;
  logic        first_r;

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

  always_comb begin
    q_entry.program_byte = in_program_byte;
    q_entry.final_byte   = in_final_byte;
    q_entry.first        = first_r;
    q_entry.version      = version_r;
    q_entry.seed         = seed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= 5'd0;
      seed_r    <= SeedReset;
      first_r   <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CfgIdxVersion: version_r <= cfg_data[4:0];
          CfgIdxSeed:    seed_r    <= cfg_data;
          default:       ;
        endcase
      end
      if (q_push) begin
        first_r <= in_final_byte;
      end
    end
  end

endmodule

>>> hdl/bsae_queue.sv
// ----------------------------------------------------------------------------
// Bech32 encoder byte queue
// Short circular queue between the front end and the symbol engine.
// ----------------------------------------------------------------------------
module bsae_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  bsae_pkg::bsae_entry_t   push_entry,
  input  logic                    pop,
  output bsae_pkg::bsae_entry_t   head,
  output bsae_pkg::bsae_q_status_t status
);
  import bsae_pkg::*;

  localparam logic [QueueAw:0] DepthCount = (QueueAw + 1)'(QueueDepth);

  bsae_entry_t        entries_r [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_r;
  logic [QueueAw-1:0] rd_ptr_r;
  logic [QueueAw:0]   count_r;

  assign head             = entries_r[rd_ptr_r];
  assign status.not_empty = (count_r != '0);
  assign status.full      = (count_r == DepthCount);

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/bsae_back.sv
// ----------------------------------------------------------------------------
// Bech32 encoder symbol engine
// Regroups queued bytes into 5-bit symbols, runs the polymod checksum and
// drives the registered character output.
// ----------------------------------------------------------------------------
module bsae_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bsae_pkg::bsae_entry_t head,
  input  logic                  head_valid,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [6:0]            out_address_char,
  output logic                  out_last_char
);
  import bsae_pkg::*;

  localparam logic [2:0] LastCnt = 3'(ChkLen - 1);

  bsae_back_state_t state_r, state_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic [29:0] chk_r, chk_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [6:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  logic        out_free;
  logic        do_sym;
  logic [11:0] acc_ld;
  logic [3:0]  pend_ld;
  logic [11:0] a_w;
  logic [3:0]  p_w;
  logic [3:0]  p_new;
  logic [3:0]  sh;
  logic [4:0]  sym;
  logic [4:0]  pad_sym;
  logic [29:0] fin_const;

  assign out_valid        = out_valid_r;
  assign out_address_char = out_char_r;
  assign out_last_char    = out_last_r;
  assign out_free         = !out_valid_r || !out_stall;

  assign acc_ld    = {acc_r[3:0], head.program_byte};
  assign pend_ld   = pend_r + 4'd8;
  assign do_sym    = (state_r == BK_SYM) ||
                     ((state_r == BK_IDLE) && head_valid && !head.first);
  assign a_w       = (state_r == BK_IDLE) ? acc_ld : acc_r;
  assign p_w       = (state_r == BK_IDLE) ? pend_ld : pend_r;
  assign sh        = p_w - 4'd5;
  assign p_new     = sh;
  assign sym       = 5'(a_w >> sh);
  assign pad_sym   = 5'(acc_r << (4'd5 - pend_r));
  assign fin_const = (head.version != 5'd0) ? Bech32mConst : Bech32Const;

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    chk_nxt       = chk_r;
    cnt_nxt       = cnt_r;
    pop           = 1'b0;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (do_sym) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sym_char(sym);
        out_last_nxt  = 1'b0;
        chk_nxt       = polymod_step(chk_r) ^ {25'd0, sym};
        acc_nxt       = a_w & ((12'd1 << p_new) - 12'd1);
        pend_nxt      = p_new;
        if (p_new >= 4'd5) begin
          state_nxt = BK_SYM;
        end else if (!head.final_byte) begin
          pop       = 1'b1;
          state_nxt = BK_IDLE;
        end else if (p_new != 4'd0) begin
          state_nxt = BK_PAD;
        end else begin
          cnt_nxt   = 3'd0;
          state_nxt = BK_CRC;
        end
      end
    end else begin
      unique case (state_r)
        BK_IDLE: begin
          if (head_valid) begin
            chk_nxt   = head.seed;
            acc_nxt   = {4'd0, head.program_byte};
            pend_nxt  = 4'd8;
            state_nxt = BK_VER;
          end
        end
        BK_VER: begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = sym_char(head.version);
            out_last_nxt  = 1'b0;
            chk_nxt       = polymod_step(chk_r) ^ {25'd0, head.version};
            state_nxt     = BK_SYM;
          end
        end
        BK_PAD: begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = sym_char(pad_sym);
            out_last_nxt  = 1'b0;
            chk_nxt       = polymod_step(chk_r) ^ {25'd0, pad_sym};
            cnt_nxt       = 3'd0;
            state_nxt     = BK_CRC;
          end
        end
        BK_CRC: begin
          chk_nxt = polymod_step(chk_r) ^ ((cnt_r == LastCnt) ? fin_const : 30'd0);
          if (cnt_r == LastCnt) begin
            cnt_nxt   = 3'd0;
            state_nxt = BK_OUT;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        BK_OUT: begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = sym_char(chk_r[29:25]);
            out_last_nxt  = (cnt_r == LastCnt);
            chk_nxt       = {chk_r[24:0], 5'd0};
            if (cnt_r == LastCnt) begin
              pop       = 1'b1;
              acc_nxt   = 12'd0;
              pend_nxt  = 4'd0;
              cnt_nxt   = 3'd0;
              state_nxt = BK_IDLE;
            end else begin
              cnt_nxt = cnt_r + 3'd1;
            end
          end
        end
        default: begin
          state_nxt = BK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      acc_r       <= 12'd0;
      pend_r      <= 4'd0;
      chk_r       <= SeedReset;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      pend_r      <= pend_nxt;
      chk_r       <= chk_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
